// ----- design/iefr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package iefr_pkg;

    localparam int IEFR_NUM_LINES = 24;
    localparam int LINE_W = 24;
    localparam int LINE_IDX_W = 5;
    localparam int MODULE_W = 16;
    localparam int BYTE_W = 8;

    localparam int POWER_ON_BIT = 2;
    localparam int RESET_PIN_BIT = 3;
    localparam int ACCESS_VIOLATION_BIT = 5;

    localparam logic [BYTE_W-1:0] ACCESS_VIOLATION_MASK = BYTE_W'(1 << ACCESS_VIOLATION_BIT);
    localparam logic [BYTE_W-1:0] BAD_ADDR_DATA = 8'hFF;

    localparam int UART0_RX_BIT = 6;
    localparam int UART0_TX_BIT = 7;
    localparam int UART1_RX_BIT = 12;
    localparam int UART1_TX_BIT = 13;

    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [2:0] {
        OP_READ = 3'd0,
        OP_WRITE = 3'd1,
        OP_LEVEL = 3'd2,
        OP_CLEAR_ENABLE = 3'd3,
        OP_ACK = 3'd4
    } iefr_op_t;

    typedef enum logic [3:0] {
        ADDR_ENABLE_LO = 4'd0,
        ADDR_ENABLE_MID = 4'd1,
        ADDR_FLAG_LO = 4'd2,
        ADDR_FLAG_MID = 4'd3,
        ADDR_MODULE_LO = 4'd4,
        ADDR_MODULE_HI = 4'd5,
        ADDR_ENABLE_HI = 4'd6,
        ADDR_FLAG_HI = 4'd7
    } iefr_addr_t;

    typedef struct packed {
        logic level;
        logic [LINE_IDX_W-1:0] line;
        logic [BYTE_W-1:0] wdata;
        iefr_addr_t addr;
        iefr_op_t op;
    } iefr_item_t;

    typedef struct packed {
        logic bad_address;
        logic uart1_tx_enable;
        logic uart1_rx_enable;
        logic uart0_tx_enable;
        logic uart0_rx_enable;
        logic [LINE_W-1:0] irq_lines;
        logic [BYTE_W-1:0] rdata;
    } iefr_result_t;

endpackage

`default_nettype wire

// ----- design/interrupt_enable_flag_registers_top.sv -----
// Channel  | Direction | Signals                           | Contents
// s_axis   | in        | tvalid, tready, tdata[23:0]       | op, addr, wdata, line, level
// m_axis   | out       | tvalid, tready, tdata[39:0]       | rdata, irq_lines, UART enables, bad
//
// The block takes one transfer per clock while the output is not stalled, and returns one result per transfer.
// Each transfer passes through the input register, then the result register.
// Reset clears all enables and module enables and leaves only the power-on flag set.
// A stalled output holds the result; the input register still takes one more
// transfer before the input side stalls.
`timescale 1ns / 1ps
`default_nettype none

module interrupt_enable_flag_registers_top #(
    parameter int NUM_LINES = iefr_pkg::IEFR_NUM_LINES
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // op[2:0], addr[6:3], wdata[14:7], line[19:15], level[20], zero[23:21]
    input  wire logic [iefr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // rdata[7:0], irq_lines[31:8], uart0_rx_enable[32], uart0_tx_enable[33],
    // uart1_rx_enable[34], uart1_tx_enable[35], bad_address[36], zero[39:37]
    output logic [iefr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
    import iefr_pkg::*;

    logic         in_valid_reg;
    logic         in_valid_next;
    iefr_item_t   in_item_reg;
    iefr_item_t   in_item;
    logic         out_valid_reg;
    logic         out_valid_next;
    iefr_result_t out_result_reg;
    iefr_result_t result;
    logic         s_accept;
    logic         advance;

    assign in_item = iefr_item_t'(s_axis_tdata[$bits(iefr_item_t)-1:0]);

    assign advance = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    iefr_regfile #(
        .NUM_LINES(NUM_LINES)
    ) u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = OUT_TDATA_W'(out_result_reg);

    a_full_pipe_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are full and stalled");

    a_held_item_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(in_item_reg))
        else $error("waiting input item lost or changed");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after an advance");

endmodule

`default_nettype wire

// ----- design/iefr_regfile.sv -----
`timescale 1ns / 1ps
`default_nettype none

module iefr_regfile #(
    parameter int NUM_LINES = iefr_pkg::IEFR_NUM_LINES
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire iefr_pkg::iefr_item_t item,
    output iefr_pkg::iefr_result_t    result
);
    import iefr_pkg::*;

    localparam logic [LINE_IDX_W-1:0] LINE_LIMIT = LINE_IDX_W'(NUM_LINES);
    localparam logic [NUM_LINES-1:0] FLAG_RESET = NUM_LINES'(1) << POWER_ON_BIT;

    logic [NUM_LINES-1:0] enable_reg;
    logic [NUM_LINES-1:0] enable_next;
    logic [NUM_LINES-1:0] flag_reg;
    logic [NUM_LINES-1:0] flag_next;
    logic [MODULE_W-1:0]  module_reg;
    logic [MODULE_W-1:0]  module_next;

    logic [LINE_W-1:0] en_cur;
    logic [LINE_W-1:0] fl_cur;
    logic [LINE_W-1:0] en_new;
    logic [LINE_W-1:0] fl_new;
    logic [LINE_W-1:0] line_mask;
    logic              line_ok;
    logic [BYTE_W-1:0] rdata;
    logic              bad;

    always_comb
    begin
        en_cur = LINE_W'(enable_reg);
        fl_cur = LINE_W'(flag_reg);
        en_new = en_cur;
        fl_new = fl_cur;
        module_next = module_reg;
        rdata = '0;
        bad = 1'b0;
        line_ok = item.line < LINE_LIMIT;
        line_mask = line_ok ? (LINE_W'(1) << item.line) : '0;

        unique case (item.op)
            OP_READ:
            begin
                unique case (item.addr)
                    ADDR_ENABLE_LO:  rdata = en_cur[7:0];
                    ADDR_ENABLE_MID: rdata = en_cur[15:8];
                    ADDR_FLAG_LO:    rdata = fl_cur[7:0] & ~ACCESS_VIOLATION_MASK;
                    ADDR_FLAG_MID:   rdata = fl_cur[15:8];
                    ADDR_MODULE_LO:  rdata = module_reg[7:0];
                    ADDR_MODULE_HI:  rdata = module_reg[15:8];
                    ADDR_ENABLE_HI:  rdata = en_cur[23:16];
                    ADDR_FLAG_HI:    rdata = fl_cur[23:16];
                    default:
                    begin
                        rdata = BAD_ADDR_DATA;
                        bad = 1'b1;
                    end
                endcase
            end
            OP_WRITE:
            begin
                unique case (item.addr)
                    ADDR_ENABLE_LO:  en_new[7:0] = item.wdata;
                    ADDR_ENABLE_MID: en_new[15:8] = item.wdata;
                    ADDR_FLAG_LO:    fl_new[7:0] = item.wdata;
                    ADDR_FLAG_MID:   fl_new[15:8] = item.wdata;
                    ADDR_MODULE_LO:  module_next[7:0] = item.wdata;
                    ADDR_MODULE_HI:  module_next[15:8] = item.wdata;
                    ADDR_ENABLE_HI:  en_new[23:16] = item.wdata;
                    ADDR_FLAG_HI:    fl_new[23:16] = item.wdata;
                    default:         bad = 1'b1;
                endcase
            end
            OP_LEVEL:
            begin
                if (item.level)
                begin
                    fl_new = fl_cur | line_mask;
                end
                else
                begin
                    fl_new = fl_cur & ~line_mask;
                end
            end
            OP_CLEAR_ENABLE:
            begin
                en_new = en_cur & ~line_mask;
            end
            OP_ACK:
            begin
                // Power-on and reset-pin flags stay set on an acknowledge.
                if (item.line != LINE_IDX_W'(POWER_ON_BIT) &&
                    item.line != LINE_IDX_W'(RESET_PIN_BIT))
                begin
                    fl_new = fl_cur & ~line_mask;
                end
            end
            default:
            begin
            end
        endcase

        enable_next = en_new[NUM_LINES-1:0];
        flag_next = fl_new[NUM_LINES-1:0];

        result.rdata = rdata;
        result.irq_lines = LINE_W'(flag_next & enable_next);
        result.uart0_rx_enable = module_next[UART0_RX_BIT];
        result.uart0_tx_enable = module_next[UART0_TX_BIT];
        result.uart1_rx_enable = module_next[UART1_RX_BIT];
        result.uart1_tx_enable = module_next[UART1_TX_BIT];
        result.bad_address = bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            flag_reg <= FLAG_RESET;
            module_reg <= '0;
        end
        else if (fire)
        begin
            enable_reg <= enable_next;
            flag_reg <= flag_next;
            module_reg <= module_next;
        end
    end

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(enable_reg) && $stable(flag_reg) && $stable(module_reg))
        else $error("register state changed without a transfer");

    a_power_on_survives_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.op == OP_ACK && item.line == LINE_IDX_W'(POWER_ON_BIT) &&
         flag_reg[POWER_ON_BIT]) |=> flag_reg[POWER_ON_BIT])
        else $error("acknowledge cleared the power-on flag");

    a_bad_only_on_bus: assert property (@(posedge clk) disable iff (!rst_n)
        result.bad_address |-> (item.op == OP_READ || item.op == OP_WRITE))
        else $error("bad address flagged on a line event");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import iefr_pkg::*;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;
    localparam logic [3:0] ADDR_UNUSED_FIRST = 4'd8;
    localparam logic [3:0] ADDR_UNUSED_LAST = 4'd15;
    localparam int LINE_IDX_LAST = 31;

    localparam int RANDOM_CMDS = 500;
    localparam int DRAIN_CMD = 250;
    localparam int IDLE_PCT = 23;
    localparam int QUIET_FIRST = 300;
    localparam int QUIET_LAST = 420;
    localparam int HOLD_OFF_AT = 150;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int TAIL_CYCLES = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic level;
        logic [LINE_IDX_W-1:0] line;
        logic [BYTE_W-1:0] wdata;
        logic [3:0] addr;
        logic [2:0] op;
    } sfr_cmd_t;

    typedef struct {
        sfr_cmd_t cmd;
        bit wait_for_drain;
    } queued_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    queued_cmd_t cmd_queue[$];
    iefr_result_t expected_results[$];

    logic [LINE_W-1:0] enable_word;
    logic [LINE_W-1:0] flag_word;
    logic [MODULE_W-1:0] module_word;

    int errors = 0;
    int cmds_total = 0;
    int cmds_accepted = 0;
    int results_seen = 0;
    int bad_accesses = 0;
    int protected_acks = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    interrupt_enable_flag_registers_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Updates the register image for one transfer and returns the result it produces.
    function automatic iefr_result_t apply_sfr_cmd(input sfr_cmd_t c);
        iefr_result_t r;
        logic [LINE_W-1:0] line_bit;
        r = '0;
        line_bit = (c.line < IEFR_NUM_LINES) ? (LINE_W'(1) << c.line) : '0;
        case (c.op)
            OP_READ:
            begin
                case (c.addr)
                    ADDR_ENABLE_LO:  r.rdata = enable_word[7:0];
                    ADDR_ENABLE_MID: r.rdata = enable_word[15:8];
                    ADDR_FLAG_LO:    r.rdata = flag_word[7:0] & ~ACCESS_VIOLATION_MASK;
                    ADDR_FLAG_MID:   r.rdata = flag_word[15:8];
                    ADDR_MODULE_LO:  r.rdata = module_word[7:0];
                    ADDR_MODULE_HI:  r.rdata = module_word[15:8];
                    ADDR_ENABLE_HI:  r.rdata = enable_word[23:16];
                    ADDR_FLAG_HI:    r.rdata = flag_word[23:16];
                    default:
                    begin
                        r.rdata = BAD_ADDR_DATA;
                        r.bad_address = 1'b1;
                        bad_accesses++;
                    end
                endcase
            end
            OP_WRITE:
            begin
                case (c.addr)
                    ADDR_ENABLE_LO:  enable_word[7:0] = c.wdata;
                    ADDR_ENABLE_MID: enable_word[15:8] = c.wdata;
                    ADDR_FLAG_LO:    flag_word[7:0] = c.wdata;
                    ADDR_FLAG_MID:   flag_word[15:8] = c.wdata;
                    ADDR_MODULE_LO:  module_word[7:0] = c.wdata;
                    ADDR_MODULE_HI:  module_word[15:8] = c.wdata;
                    ADDR_ENABLE_HI:  enable_word[23:16] = c.wdata;
                    ADDR_FLAG_HI:    flag_word[23:16] = c.wdata;
                    default:
                    begin
                        r.bad_address = 1'b1;
                        bad_accesses++;
                    end
                endcase
            end
            OP_LEVEL:
            begin
                if (c.level)
                    flag_word = flag_word | line_bit;
                else
                    flag_word = flag_word & ~line_bit;
            end
            OP_CLEAR_ENABLE:
                enable_word = enable_word & ~line_bit;
            OP_ACK:
            begin
                if (c.line == POWER_ON_BIT || c.line == RESET_PIN_BIT)
                    protected_acks++;
                else
                    flag_word = flag_word & ~line_bit;
            end
            default:
                ;
        endcase
        r.irq_lines = flag_word & enable_word;
        r.uart0_rx_enable = module_word[UART0_RX_BIT];
        r.uart0_tx_enable = module_word[UART0_TX_BIT];
        r.uart1_rx_enable = module_word[UART1_RX_BIT];
        r.uart1_tx_enable = module_word[UART1_TX_BIT];
        return r;
    endfunction

    function automatic sfr_cmd_t make_cmd(input logic [2:0] op, input logic [3:0] addr,
                                          input logic [BYTE_W-1:0] wdata,
                                          input int line,
                                          input logic level);
        sfr_cmd_t c;
        c.op = op;
        c.addr = addr;
        c.wdata = wdata;
        c.line = LINE_IDX_W'(line);
        c.level = level;
        return c;
    endfunction

    function automatic sfr_cmd_t random_cmd();
        sfr_cmd_t c;
        int pick;
        c.level = 1'($urandom_range(1));
        c.wdata = BYTE_W'($urandom_range(255));
        c.addr = 4'($urandom_range(7));
        c.line = ($urandom_range(9) == 0) ? LINE_IDX_W'($urandom_range(31))
                                          : LINE_IDX_W'($urandom_range(IEFR_NUM_LINES - 1));
        pick = $urandom_range(99);
        if (pick < 30)
            c.op = OP_READ;
        else if (pick < 55)
            c.op = OP_WRITE;
        else if (pick < 70)
            c.op = OP_LEVEL;
        else if (pick < 80)
            c.op = OP_CLEAR_ENABLE;
        else if (pick < 90)
        begin
            c.op = OP_ACK;
            if ($urandom_range(3) == 0)
                c.line = $urandom_range(1) ? LINE_IDX_W'(POWER_ON_BIT)
                                           : LINE_IDX_W'(RESET_PIN_BIT);
        end
        else if (pick < 95)
        begin
            c.op = $urandom_range(1) ? OP_WRITE : OP_READ;
            c.addr = 4'($urandom_range(ADDR_UNUSED_LAST, ADDR_UNUSED_FIRST));
        end
        else
            c.op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        return c;
    endfunction

    task automatic add_cmd(input sfr_cmd_t c, input bit wait_for_drain);
        queued_cmd_t q;
        q.cmd = c;
        q.wait_for_drain = wait_for_drain;
        cmd_queue.push_back(q);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic offer;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(
                    apply_sfr_cmd(sfr_cmd_t'(s_axis_tdata[$bits(sfr_cmd_t)-1:0])));
                cmds_accepted++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                offer = cmd_queue.size() != 0;
                if (offer && cmd_queue[0].wait_for_drain && expected_results.size() != 0)
                    offer = 1'b0;
                if (offer && !(cmds_accepted >= QUIET_FIRST && cmds_accepted < QUIET_LAST)
                    && $urandom_range(99) < IDLE_PCT)
                    offer = 1'b0;
                if (offer)
                begin
                    s_axis_tdata <= IN_TDATA_W'(cmd_queue[0].cmd);
                    cmd_queue.pop_front();
                end
                s_axis_tvalid <= offer;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        iefr_result_t got;
        iefr_result_t want;
        logic ready_next;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = iefr_result_t'(m_axis_tdata[$bits(iefr_result_t)-1:0]);
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected, tdata %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.rdata !== want.rdata)
                    begin
                        $error("rdata: expected %h, got %h", want.rdata, got.rdata);
                        errors++;
                    end
                    if (got.irq_lines !== want.irq_lines)
                    begin
                        $error("irq_lines: expected %h, got %h", want.irq_lines, got.irq_lines);
                        errors++;
                    end
                    if (got.uart0_rx_enable !== want.uart0_rx_enable)
                    begin
                        $error("uart0_rx_enable: expected %b, got %b",
                               want.uart0_rx_enable, got.uart0_rx_enable);
                        errors++;
                    end
                    if (got.uart0_tx_enable !== want.uart0_tx_enable)
                    begin
                        $error("uart0_tx_enable: expected %b, got %b",
                               want.uart0_tx_enable, got.uart0_tx_enable);
                        errors++;
                    end
                    if (got.uart1_rx_enable !== want.uart1_rx_enable)
                    begin
                        $error("uart1_rx_enable: expected %b, got %b",
                               want.uart1_rx_enable, got.uart1_rx_enable);
                        errors++;
                    end
                    if (got.uart1_tx_enable !== want.uart1_tx_enable)
                    begin
                        $error("uart1_tx_enable: expected %b, got %b",
                               want.uart1_tx_enable, got.uart1_tx_enable);
                        errors++;
                    end
                    if (got.bad_address !== want.bad_address)
                    begin
                        $error("bad_address: expected %b, got %b",
                               want.bad_address, got.bad_address);
                        errors++;
                    end
                end
                if (results_seen == HOLD_OFF_AT)
                    hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                ready_next = 1'b0;
                hold_left--;
            end
            else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST)
                ready_next = 1'b1;
            else
                ready_next = $urandom_range(99) >= IDLE_PCT;
            m_axis_tready <= ready_next;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles.", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        enable_word = '0;
        flag_word = LINE_W'(1) << POWER_ON_BIT;
        module_word = '0;

        // The power-on flag is visible right after reset.
        add_cmd(make_cmd(OP_READ, ADDR_FLAG_LO, 8'h00, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_WRITE, ADDR_ENABLE_LO, 8'hFF, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_WRITE, ADDR_ENABLE_MID, 8'hFF, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_WRITE, ADDR_ENABLE_HI, 8'hFF, 0, 1'b0), 1'b0);
        // The access-violation flag is stored but reads back as zero.
        add_cmd(make_cmd(OP_WRITE, ADDR_FLAG_LO, 8'hFF, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_READ, ADDR_FLAG_LO, 8'h00, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_WRITE, ADDR_FLAG_MID, 8'hFF, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_WRITE, ADDR_FLAG_HI, 8'hFF, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_WRITE, ADDR_MODULE_LO, 8'hFF, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_WRITE, ADDR_MODULE_HI, 8'hFF, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_READ, ADDR_MODULE_HI, 8'h00, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_READ, ADDR_ENABLE_HI, 8'h00, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_WRITE, ADDR_UNUSED_LAST, 8'h00, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_READ, ADDR_UNUSED_FIRST, 8'h00, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_ACK, ADDR_ENABLE_LO, 8'h00, POWER_ON_BIT, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_ACK, ADDR_ENABLE_LO, 8'h00, RESET_PIN_BIT, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_ACK, ADDR_ENABLE_LO, 8'h00, 0, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_LEVEL, ADDR_ENABLE_LO, 8'h00, IEFR_NUM_LINES - 1, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_LEVEL, ADDR_ENABLE_LO, 8'h00, 1, 1'b1), 1'b0);
        add_cmd(make_cmd(OP_CLEAR_ENABLE, ADDR_ENABLE_LO, 8'h00, IEFR_NUM_LINES - 1, 1'b0),
                1'b0);
        // A line index past the last line leaves every register unchanged.
        add_cmd(make_cmd(OP_LEVEL, ADDR_ENABLE_LO, 8'h00, LINE_IDX_LAST, 1'b0), 1'b0);
        add_cmd(make_cmd(OP_SPARE_LAST, ADDR_UNUSED_LAST, 8'hFF, LINE_IDX_LAST, 1'b1), 1'b0);
        add_cmd(make_cmd(OP_WRITE, ADDR_MODULE_LO, 8'h00, 0, 1'b0), 1'b0);

        for (int i = 0; i < RANDOM_CMDS; i++)
            add_cmd(random_cmd(), i == DRAIN_CMD);
        cmds_total = cmd_queue.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (cmds_accepted < cmds_total || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d command transfers and %0d result transfers, with a long output stall",
                 cmds_accepted, results_seen);
        $display("and a full drain; %0d unimplemented-address accesses, %0d protected-flag acks.",
                 bad_accesses, protected_acks);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
design/iefr_pkg.sv
design/iefr_regfile.sv
design/interrupt_enable_flag_registers_top.sv
dv/tb.sv
